[src/fly_camera_pose_integrator_unit_defines.svh]
// assertion macros for the pose integrator
`ifndef FLY_CAMERA_POSE_INTEGRATOR_UNIT_DEFINES_SVH
`define FLY_CAMERA_POSE_INTEGRATOR_UNIT_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define FCP_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// assert that a condition implies a consequence on the next edge
`define FCP_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

[src/fcp_pkg.sv]
// shared types and constants of the pose integrator
package fcp_pkg;
    localparam logic [15:0] SIN_C1 = 16'd51472;
    localparam logic [15:0] SIN_C2 = 16'd21024;
    localparam logic [15:0] SIN_C3 = 16'd2320;

    typedef enum logic [2:0]
    {
        REG_LOOK_RATE = 3'd0,
        REG_MOVE_RATE = 3'd1,
        REG_CLIMB_RATE = 3'd2,
        REG_PITCH_LIMIT = 3'd3,
        REG_FLOOR_HEIGHT = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0]
    {
        OP_IDLE = 4'd0,
        OP_LOAD = 4'd1,
        OP_ANGLE = 4'd2,
        OP_SINE = 4'd3,
        OP_DIST = 4'd4,
        OP_MOVE = 4'd5,
        OP_COMMIT = 4'd6
    } op_t;

    typedef struct packed
    {
        op_t op;
        logic [2:0] sub;
    } cmd_t;

    typedef struct packed
    {
        logic sine_done;
    } status_t;
endpackage

[src/fcp_ctrl.sv]
// sequencer of the pose integrator
module fcp_ctrl
    import fcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  status_t status,
    input  logic out_free,
    output cmd_t cmd,
    output logic busy
);
    typedef enum logic [6:0]
    {
        S_IDLE = 7'b0000001,
        S_ANGLE = 7'b0000010,
        S_SINE = 7'b0000100,
        S_DIST = 7'b0001000,
        S_MOVE = 7'b0010000,
        S_WAIT = 7'b0100000,
        S_COMMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] sub_reg, sub_next;

    always_comb
    begin
        state_next = state_reg;
        sub_next = sub_reg;
        cmd.op = OP_IDLE;
        cmd.sub = sub_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_ANGLE;
                    sub_next = '0;
                end
            end
            S_ANGLE:
            begin
                cmd.op = OP_ANGLE;
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd3)
                begin
                    state_next = S_SINE;
                    sub_next = '0;
                end
            end
            S_SINE:
            begin
                cmd.op = OP_SINE;
                if (status.sine_done)
                begin
                    sub_next = sub_reg + 3'd1;
                    if (sub_reg == 3'd3)
                    begin
                        state_next = S_DIST;
                        sub_next = '0;
                    end
                end
            end
            S_DIST:
            begin
                cmd.op = OP_DIST;
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd6)
                begin
                    state_next = S_MOVE;
                    sub_next = '0;
                end
            end
            S_MOVE:
            begin
                cmd.op = OP_MOVE;
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd7)
                begin
                    state_next = S_WAIT;
                    sub_next = '0;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.op = OP_COMMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sub_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg <= sub_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
endmodule

[src/fcp_sine.sv]
// iterative fixed-point sine over a quarter-wave polynomial
module fcp_sine
    import fcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [15:0] angle,
    output logic done,
    output logic signed [15:0] result
);
    logic [2:0] step_reg;
    logic run_reg;
    logic [14:0] z_reg;
    logic neg_reg;
    logic [31:0] z2_reg;
    logic [31:0] t_reg;
    logic [35:0] prod;
    logic [14:0] z_in;
    logic [17:0] mul_a;
    logic [17:0] mul_b;
    logic [31:0] y_w;
    logic [15:0] y_c;

    assign z_in = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};

    always_comb
    begin
        mul_a = {3'b000, z_reg};
        mul_b = {3'b000, z_reg};
        case (step_reg)
            3'd0: mul_b = {3'b000, z_reg};
            3'd1: begin mul_a = z2_reg[17:0]; mul_b = {2'b00, SIN_C3}; end
            3'd2: begin mul_a = z2_reg[17:0]; mul_b = t_reg[17:0]; end
            default: begin mul_a = {3'b000, z_reg}; mul_b = t_reg[17:0]; end
        endcase
        prod = mul_a * mul_b;
    end

    assign y_w = {11'd0, prod[35:15]} > 32'd16384 ? 32'd16384 : {11'd0, prod[35:15]};
    assign y_c = y_w[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            step_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start && !run_reg)
            begin
                run_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    run_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !run_reg)
        begin
            z_reg <= z_in;
            neg_reg <= angle[15];
        end
        else if (run_reg)
        begin
            case (step_reg)
                3'd0: z2_reg <= {14'd0, prod[31:14]};
                3'd1: t_reg <= {16'd0, SIN_C2} - {14'd0, prod[31:14]};
                3'd2: t_reg <= {16'd0, SIN_C1} - {14'd0, prod[31:14]};
                default: result <= neg_reg ? -$signed(y_c) : $signed(y_c);
            endcase
        end
    end
endmodule

[src/fcp_datapath.sv]
// registers, shared multiplier and accumulators of the pose integrator
module fcp_datapath
    import fcp_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int POS_FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output status_t status,
    input  logic [95:0] in_data,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data,
    output logic [127:0] out_data
);
    localparam int DSH = 38 - POS_FRAC_BITS;
    localparam logic signed [ANGLE_BITS-1:0] QMAX = (1 <<< (ANGLE_BITS - 2)) - 1;
    localparam logic signed [63:0] XR = -64'sd1500 <<< POS_FRAC_BITS;
    localparam logic signed [63:0] YR = 64'sd60 <<< POS_FRAC_BITS;
    localparam logic signed [63:0] ZR = 64'sd1600 <<< POS_FRAC_BITS;

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic [15:0] to16(input logic signed [ANGLE_BITS-1:0] a);
        logic signed [63:0] w;
        w = 64'(a);
        if (ANGLE_BITS >= 16)
            return 16'(w >>> (ANGLE_BITS - 16));
        else
            return 16'(w <<< (16 - ANGLE_BITS));
    endfunction

    logic [15:0] look_rate_reg;
    logic [23:0] move_rate_reg, climb_rate_reg;
    logic [13:0] pitch_limit_reg;
    logic signed [31:0] floor_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [ANGLE_BITS-1:0] yaw_reg, pitch_reg;
    logic signed [ANGLE_BITS-1:0] ny_reg, np_reg;
    logic signed [15:0] mv_reg, st_reg, cl_reg, tu_reg, ti_reg;
    logic [15:0] dt_reg;
    logic signed [63:0] tmp_reg;
    logic signed [15:0] cp_reg, sp_reg, cy_reg, sy_reg;
    logic signed [31:0] fx_reg, fz_reg;
    logic signed [63:0] df_reg, ds_reg, dc_reg;
    logic signed [63:0] ax_reg, ay_reg, az_reg;
    logic signed [39:0] ma;
    logic signed [24:0] mb;
    logic signed [63:0] mp;
    logic signed [63:0] rnd30, rndd, rnd14;
    logic signed [63:0] lim_w, p_w;
    logic sine_go_reg;
    logic [15:0] sine_ang;
    logic sine_done;
    logic signed [15:0] sine_val;
    logic signed [31:0] ny_sat;
    logic signed [31:0] py_new;
    logic [15:0] hd_w, tl_w;

    fcp_sine u_sine
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(sine_go_reg),
        .angle(sine_ang),
        .done(sine_done),
        .result(sine_val)
    );

    always_comb
    begin
        case (cmd.sub[1:0])
            2'd0: sine_ang = to16(np_reg + ANGLE_BITS'(1 <<< (ANGLE_BITS - 2)));
            2'd1: sine_ang = to16(np_reg);
            2'd2: sine_ang = to16(ny_reg + ANGLE_BITS'(1 <<< (ANGLE_BITS - 2)));
            default: sine_ang = to16(ny_reg);
        endcase
    end
    assign status.sine_done = sine_done;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_ANGLE:
            begin
                case (cmd.sub)
                    3'd0: begin ma = 40'(tu_reg); mb = 25'({1'b0, look_rate_reg}); end
                    3'd1: begin ma = 40'(tmp_reg); mb = 25'({1'b0, dt_reg}); end
                    3'd2: begin ma = 40'(ti_reg); mb = 25'({1'b0, look_rate_reg}); end
                    default: begin ma = 40'(tmp_reg); mb = 25'({1'b0, dt_reg}); end
                endcase
            end
            OP_DIST:
            begin
                case (cmd.sub)
                    3'd0: begin ma = 40'(mv_reg); mb = 25'({1'b0, move_rate_reg}); end
                    3'd1: begin ma = 40'(tmp_reg); mb = 25'({1'b0, dt_reg}); end
                    3'd2: begin ma = 40'(st_reg); mb = 25'({1'b0, move_rate_reg}); end
                    3'd3: begin ma = 40'(tmp_reg); mb = 25'({1'b0, dt_reg}); end
                    3'd4: begin ma = 40'(cl_reg); mb = 25'({1'b0, climb_rate_reg}); end
                    3'd5: begin ma = 40'(tmp_reg); mb = 25'({1'b0, dt_reg}); end
                    default: begin ma = 40'(cp_reg); mb = 25'(sy_reg); end
                endcase
            end
            OP_MOVE:
            begin
                case (cmd.sub)
                    3'd0: begin ma = 40'(cp_reg); mb = 25'(cy_reg); end
                    3'd1: begin ma = 40'(df_reg); mb = 25'(fx_reg); end
                    3'd2: begin ma = 40'(ds_reg); mb = 25'(cy_reg); end
                    3'd3: begin ma = 40'(df_reg); mb = 25'(sp_reg); end
                    3'd4: begin ma = 40'(df_reg); mb = 25'(fz_reg); end
                    3'd5: begin ma = 40'(ds_reg); mb = 25'(sy_reg); end
                    default: begin ma = '0; mb = '0; end
                endcase
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        mp = ma * mb;
        rnd30 = (mp + (64'sd1 <<< 29)) >>> 30;
        rndd = (mp + (64'sd1 <<< (DSH - 1))) >>> DSH;
        rnd14 = (mp + (64'sd1 <<< 13)) >>> 14;
        lim_w = (64'({1'b0, pitch_limit_reg}) > 64'(QMAX)) ? 64'(QMAX)
            : 64'({1'b0, pitch_limit_reg});
        p_w = 64'(pitch_reg) + rnd30;
        ny_sat = sat(ay_reg);
        py_new = (ny_sat < floor_reg) ? floor_reg : ny_sat;
        hd_w = to16(ny_reg);
        tl_w = to16(np_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_rate_reg <= 16'd20861;
            move_rate_reg <= 24'd25600;
            climb_rate_reg <= 24'd12800;
            pitch_limit_reg <= 14'd14602;
            floor_reg <= 32'sd327680;
            px_reg <= sat(XR);
            py_reg <= sat(YR);
            pz_reg <= sat(ZR);
            yaw_reg <= '0;
            pitch_reg <= '0;
            sine_go_reg <= 1'b0;
        end
        else
        begin
            sine_go_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOOK_RATE: look_rate_reg <= cfg_data[15:0];
                    REG_MOVE_RATE: move_rate_reg <= cfg_data[23:0];
                    REG_CLIMB_RATE: climb_rate_reg <= cfg_data[23:0];
                    REG_PITCH_LIMIT: pitch_limit_reg <= cfg_data[13:0];
                    REG_FLOOR_HEIGHT: floor_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_ANGLE && cmd.sub == 3'd3)
                sine_go_reg <= 1'b1;
            if (cmd.op == OP_SINE && sine_done && cmd.sub != 3'd3)
                sine_go_reg <= 1'b1;
            if (cmd.op == OP_COMMIT)
            begin
                px_reg <= sat(ax_reg);
                py_reg <= py_new;
                pz_reg <= sat(az_reg);
                yaw_reg <= ny_reg;
                pitch_reg <= np_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mv_reg <= in_data[15:0];
                st_reg <= in_data[31:16];
                cl_reg <= in_data[47:32];
                tu_reg <= in_data[63:48];
                ti_reg <= in_data[79:64];
                dt_reg <= in_data[95:80];
            end
            OP_ANGLE:
            begin
                case (cmd.sub)
                    3'd1: ny_reg <= ANGLE_BITS'(64'(yaw_reg) + rnd30);
                    3'd3:
                    begin
                        if (p_w > lim_w)
                            np_reg <= ANGLE_BITS'(lim_w);
                        else if (p_w < -lim_w)
                            np_reg <= ANGLE_BITS'(-lim_w);
                        else
                            np_reg <= ANGLE_BITS'(p_w);
                    end
                    default: tmp_reg <= mp;
                endcase
            end
            OP_SINE:
            begin
                if (sine_done)
                begin
                    case (cmd.sub[1:0])
                        2'd0: cp_reg <= sine_val;
                        2'd1: sp_reg <= sine_val;
                        2'd2: cy_reg <= sine_val;
                        default: sy_reg <= sine_val;
                    endcase
                end
            end
            OP_DIST:
            begin
                case (cmd.sub)
                    3'd1: df_reg <= rndd;
                    3'd3: ds_reg <= rndd;
                    3'd5: dc_reg <= rndd;
                    3'd6: fx_reg <= rnd14[31:0];
                    default: tmp_reg <= mp;
                endcase
            end
            OP_MOVE:
            begin
                case (cmd.sub)
                    3'd0:
                    begin
                        fz_reg <= -rnd14[31:0];
                        ax_reg <= 64'(px_reg);
                        ay_reg <= 64'(py_reg) + dc_reg;
                        az_reg <= 64'(pz_reg);
                    end
                    3'd1, 3'd2: ax_reg <= ax_reg + rnd14;
                    3'd3: ay_reg <= ay_reg + rnd14;
                    3'd4, 3'd5: az_reg <= az_reg + rnd14;
                    default: ;
                endcase
            end
            OP_COMMIT:
            begin
                out_data <= {1'b0, tl_w[14:0], hd_w, sat(az_reg), py_new, sat(ax_reg)};
            end
            default: ;
        endcase
    end
endmodule

[src/fly_camera_pose_integrator_unit.sv]
// top level of the free-fly camera pose integrator
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      sticks and frame time
// m_axis    out  m_axis_tvalid/tready      position, heading, tilt
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
// one request at a time: a new request is accepted only after the last one commits
// four sine runs and the shared multiplier steps make up the work of each request
// reset restores the start pose and register defaults; no clearing pass
// a result not yet taken holds the next request in the wait state
// configuration is accepted only while the core is idle
`include "fly_camera_pose_integrator_unit_defines.svh"
module fly_camera_pose_integrator_unit
    import fcp_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int POS_FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // move, strafe, climb, turn, tilt axis, frame_time
    input  logic [95:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // pos_x, pos_y, pos_z, heading, tilt, zero pad
    output logic [127:0] m_axis_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);
    cmd_t cmd;
    status_t status;
    logic busy;
    logic out_free;
    logic start;
    logic out_valid_reg;

    assign s_axis_tready = !busy;
    assign start = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = !busy;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    fcp_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .status(status),
        .out_free(out_free),
        .cmd(cmd),
        .busy(busy)
    );

    fcp_datapath #(.ANGLE_BITS(ANGLE_BITS), .POS_FRAC_BITS(POS_FRAC_BITS)) u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .status(status),
        .in_data(s_axis_tdata),
        .cfg_we(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_data(m_axis_tdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_COMMIT)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    `FCP_ASSERT_IMPL(a_no_accept_busy, busy, !s_axis_tready, "accept while busy")
    `FCP_ASSERT_NEXT(a_commit_valid, cmd.op == OP_COMMIT, m_axis_tvalid, "commit lost")
    `FCP_ASSERT_IMPL(a_commit_free, cmd.op == OP_COMMIT, out_free, "result overwritten")
endmodule

[tb/sv/tb.sv]
// testbench for the pose integrator: scoreboard prediction of every pose update
`timescale 1ns / 100ps
module tb;
    import fcp_pkg::*;

    typedef struct packed
    {
        logic [14:0] tl;
        logic [15:0] hd;
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } pose_t;

    class pose_scoreboard;
        logic [15:0] look_rate;
        logic [23:0] move_rate;
        logic [23:0] climb_rate;
        logic [13:0] pitch_limit;
        logic signed [31:0] floor_height;
        logic signed [31:0] cam_x, cam_y, cam_z;
        logic signed [15:0] yaw, pitch;
        pose_t pending[$];
        int errors;
        int checked;

        function new();
            look_rate = 16'd20861;
            move_rate = 24'd25600;
            climb_rate = 24'd12800;
            pitch_limit = 14'd14602;
            floor_height = 32'sd327680;
            cam_x = -32'sd1500 * 65536;
            cam_y = 32'sd60 * 65536;
            cam_z = 32'sd1600 * 65536;
            yaw = 0;
            pitch = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] d);
            case (idx)
                REG_LOOK_RATE: look_rate = d[15:0];
                REG_MOVE_RATE: move_rate = d[23:0];
                REG_CLIMB_RATE: climb_rate = d[23:0];
                REG_PITCH_LIMIT: pitch_limit = d[13:0];
                REG_FLOOR_HEIGHT: floor_height = d;
                default: ;
            endcase
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint sine(longint ang);
            logic [15:0] a;
            longint z, z2, t, y;
            a = ang[15:0];
            z = a[14] ? 16384 - a[13:0] : a[13:0];
            z2 = (z * z) >>> 14;
            t = 21024 - ((z2 * 2320) >>> 14);
            t = 51472 - ((z2 * t) >>> 14);
            y = (z * t) >>> 15;
            if (y > 16384)
                y = 16384;
            return a[15] ? -y : y;
        endfunction

        function void note_frame(logic [95:0] d);
            longint mv, st, cl, tu, ti, dt, lim, y, p;
            longint cp, sp, cy, sy, fx, fz, df, ds, dc, nx, ny, nz;
            pose_t r;
            mv = $signed(d[15:0]);
            st = $signed(d[31:16]);
            cl = $signed(d[47:32]);
            tu = $signed(d[63:48]);
            ti = $signed(d[79:64]);
            dt = d[95:80];
            y = yaw + round_shift(tu * look_rate * dt, 30);
            y = $signed(y[15:0]);
            yaw = y[15:0];
            lim = pitch_limit;
            if (lim > 16383)
                lim = 16383;
            p = pitch + round_shift(ti * look_rate * dt, 30);
            if (p > lim)
                p = lim;
            else if (p < -lim)
                p = -lim;
            pitch = p[15:0];
            cp = sine(p + 16384);
            sp = sine(p);
            cy = sine(y + 16384);
            sy = sine(y);
            fx = round_shift(cp * sy, 14);
            fz = -round_shift(cp * cy, 14);
            df = round_shift(mv * longint'(move_rate) * dt, 22);
            ds = round_shift(st * longint'(move_rate) * dt, 22);
            dc = round_shift(cl * longint'(climb_rate) * dt, 22);
            nx = cam_x + round_shift(df * fx, 14) + round_shift(ds * cy, 14);
            ny = cam_y + round_shift(df * sp, 14) + dc;
            nz = cam_z + round_shift(df * fz, 14) + round_shift(ds * sy, 14);
            cam_x = 32'(sat(nx));
            cam_y = 32'(sat(ny));
            cam_z = 32'(sat(nz));
            if (cam_y < floor_height)
                cam_y = floor_height;
            r.px = cam_x;
            r.py = cam_y;
            r.pz = cam_z;
            r.hd = y[15:0];
            r.tl = p[14:0];
            pending.push_back(r);
        endfunction

        function void check_pose(logic [127:0] d);
            pose_t e;
            pose_t a;
            a = d[126:0];
            if (pending.size() == 0)
            begin
                $display("%0t unexpected pose, actual %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a.px !== e.px)
                $display("%0t pos_x expected %0d actual %0d", $time, e.px, a.px);
            if (a.py !== e.py)
                $display("%0t pos_y expected %0d actual %0d", $time, e.py, a.py);
            if (a.pz !== e.pz)
                $display("%0t pos_z expected %0d actual %0d", $time, e.pz, a.pz);
            if (a.hd !== e.hd)
                $display("%0t heading expected %h actual %h", $time, e.hd, a.hd);
            if (a.tl !== e.tl)
                $display("%0t tilt expected %h actual %h", $time, e.tl, a.tl);
            if (a !== e || d[127] !== 1'b0)
                errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [127:0] m_axis_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    pose_scoreboard sb = new();
    bit calm = 0;
    int frames = 0;
    int stall_left = 0;
    longint cycles = 0;

    always #5 clk = ~clk;

    fly_camera_pose_integrator_unit u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pose(m_axis_tdata);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_frame(s_axis_tdata);
        if (cycles > 2000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side stalls in bursts
    always @(negedge clk)
    begin
        if (calm)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_frame(logic [15:0] mv, logic [15:0] st, logic [15:0] cl,
                              logic [15:0] tu, logic [15:0] ti, logic [15:0] dt);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dt, ti, tu, cl, st, mv};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        frames++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom());
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic random_frames(int n);
        for (int i = 0; i < n; i++)
            send_frame(rand_axis(), rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                       16'($urandom_range(0, 2000)));
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        send_frame(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1092);
        send_frame(-16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'hffff);
        send_frame(16'sd0, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 16'hffff);
        send_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
        send_frame(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        send_frame(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff);
        send_frame(16'sd0, 16'sd0, -16'sd16384, 16'sd0, -16'sd16384, 16'hffff);
        drain();

        // pitch limit at its maximum just under a quarter turn, overflowing moves, low floor
        write_reg(REG_LOOK_RATE, 32'hffff);
        write_reg(REG_MOVE_RATE, 32'hffffff);
        write_reg(REG_CLIMB_RATE, 32'hffffff);
        write_reg(REG_PITCH_LIMIT, 32'h3fff);
        write_reg(REG_FLOOR_HEIGHT, 32'h80000000);
        for (int i = 0; i < 12; i++)
            send_frame(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        for (int i = 0; i < 8; i++)
            send_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
        random_frames(300);
        drain();

        write_reg(REG_LOOK_RATE, 32'd0);
        write_reg(REG_MOVE_RATE, 32'd0);
        write_reg(REG_CLIMB_RATE, 32'd0);
        write_reg(REG_PITCH_LIMIT, 32'd0);
        write_reg(REG_FLOOR_HEIGHT, 32'h7fffffff);
        random_frames(100);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_LOOK_RATE, $urandom());
            write_reg(REG_MOVE_RATE, $urandom_range(0, 200000));
            write_reg(REG_CLIMB_RATE, $urandom_range(0, 200000));
            write_reg(REG_PITCH_LIMIT, $urandom());
            write_reg(REG_FLOOR_HEIGHT, $urandom());
            random_frames(270);
            drain();
        end

        write_reg(REG_LOOK_RATE, 32'd20861);
        write_reg(REG_MOVE_RATE, 32'd25600);
        write_reg(REG_CLIMB_RATE, 32'd12800);
        write_reg(REG_PITCH_LIMIT, 32'd14602);
        write_reg(REG_FLOOR_HEIGHT, 32'd327680);
        random_frames(150);
        calm = 1;
        random_frames(150);
        drain();

        $display("covered %0d frames, %0d poses checked, eight register settings",
                 frames, sb.checked);
        $display("including stick and time extremes, pitch clamping and saturation");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
